### rtl/lsch_pkg.sv
// ----------------------------------------------------------------------------
// Lottery scheduler package
// Command and status codes, sequencer states and fixed widths shared by the
// lottery scheduler modules.
// ----------------------------------------------------------------------------
package lsch_pkg;

    localparam int RND_W       = 32;
    localparam int DIV_CNT_W   = $clog2(RND_W);
    localparam int ID_W        = 8;
    localparam int TICKET_IN_W = 16;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RND_W - 1);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WINNER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WALK
    } state_t;

endpackage

### rtl/lsch_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lsch_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lsch_cmpsub.sv
// ----------------------------------------------------------------------------
// Shared compare-subtract unit
// Computes a - b and flags a borrow when b is greater than a.
// ----------------------------------------------------------------------------
module lsch_cmpsub #(
    parameter int WIDTH = 24
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             borrow
);

    logic [WIDTH:0] full_diff;

    assign full_diff = {1'b0, a} - {1'b0, b};
    assign diff      = full_diff[WIDTH-1:0];
    assign borrow    = full_diff[WIDTH];

endmodule

### rtl/lottery_scheduler.sv
// ----------------------------------------------------------------------------
// Lottery scheduler
// An add returns its result in the cycle after its transfer, so adds can follow
// back to back while the receiver is ready. A draw takes a load step, a
// restoring modulo and a table walk up to the winning slot, all on one
// compare-subtract unit; the next item is taken at the earliest together with
// the transfer of the result. Reset clears the entry count, the ticket total
// and the sequencer; the table contents are read only after they are written.
// ----------------------------------------------------------------------------
module lottery_scheduler #(
    parameter int MAX_ENTRIES = 64,
    parameter int TICKET_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [lsch_pkg::ID_W-1:0]        s_process_id,
    input  logic [lsch_pkg::TICKET_IN_W-1:0] s_ticket_count,
    input  logic [lsch_pkg::RND_W-1:0]       s_random_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lsch_pkg::STATUS_W-1:0]    m_status,
    output logic [lsch_pkg::ID_W-1:0]        m_winner_id,
    output logic [lsch_pkg::SLOT_OUT_W-1:0]  m_winner_slot
);

    localparam int SLOT_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_W = TICKET_BITS + CNT_W;
    localparam int UNIT_W  = TOTAL_W + 1;
    localparam int ENTRY_W = lsch_pkg::ID_W + TICKET_BITS;

    lsch_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [TOTAL_W-1:0]                 total_reg, total_next;
    logic [TOTAL_W-1:0]                 rem_reg, rem_next;
    logic [lsch_pkg::RND_W-1:0]         rnd_reg, rnd_next;
    logic [lsch_pkg::DIV_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [SLOT_W-1:0]                  slot_reg, slot_next;
    logic                               m_valid_reg, m_valid_next;
    logic [lsch_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [lsch_pkg::ID_W-1:0]          m_winner_id_reg, m_winner_id_next;
    logic [lsch_pkg::SLOT_OUT_W-1:0]    m_winner_slot_reg, m_winner_slot_next;

    logic                s_accept;
    logic                table_full;
    logic                draw_go;
    logic                walk_last;
    logic [CNT_W-1:0]    count_minus_one;
    logic [TICKET_BITS-1:0] tickets_in;
    logic                ram_wr_en;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic [TICKET_BITS-1:0] rd_tickets;
    logic [lsch_pkg::ID_W-1:0] rd_id;
    logic [UNIT_W-1:0]   unit_a, unit_b, unit_diff;
    logic                unit_borrow;

    assign s_ready    = (state_reg == lsch_pkg::S_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept   = s_valid && s_ready;
    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));
    assign draw_go    = (count_reg != '0) && (total_reg != '0);
    assign tickets_in = TICKET_BITS'(s_ticket_count);
    assign ram_wr_en  = s_accept && (s_command == lsch_pkg::CMD_ADD) && !table_full;

    assign count_minus_one = count_reg - CNT_W'(1);
    assign walk_last       = (slot_reg == count_minus_one[SLOT_W-1:0]);

    assign rd_tickets = ram_rd_data[TICKET_BITS-1:0];
    assign rd_id      = ram_rd_data[ENTRY_W-1:TICKET_BITS];

    lsch_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[SLOT_W-1:0]),
        .wr_data ({s_process_id, tickets_in}),
        .rd_addr (slot_next),
        .rd_data (ram_rd_data)
    );

    // The modulo shifts in one random bit per cycle; the walk subtracts each
    // entry's tickets from the remainder until one exceeds it or the last is read.
    always_comb begin
        if (state_reg == lsch_pkg::S_WALK) begin
            unit_a = {1'b0, rem_reg};
            unit_b = UNIT_W'(rd_tickets);
        end else begin
            unit_a = {rem_reg, rnd_reg[lsch_pkg::RND_W-1]};
            unit_b = {1'b0, total_reg};
        end
    end

    lsch_cmpsub #(
        .WIDTH (UNIT_W)
    ) u_unit (
        .a      (unit_a),
        .b      (unit_b),
        .diff   (unit_diff),
        .borrow (unit_borrow)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsch_pkg::S_IDLE: begin
                if (s_accept && (s_command == lsch_pkg::CMD_DRAW) && draw_go) begin
                    state_next = lsch_pkg::S_DIV;
                end
            end
            lsch_pkg::S_DIV: begin
                if (bit_cnt_reg == lsch_pkg::DIV_LAST) begin
                    state_next = lsch_pkg::S_WALK;
                end
            end
            lsch_pkg::S_WALK: begin
                if (unit_borrow || walk_last) begin
                    state_next = lsch_pkg::S_IDLE;
                end
            end
            default: state_next = lsch_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        count_next         = count_reg;
        total_next         = total_reg;
        rem_next           = rem_reg;
        rnd_next           = rnd_reg;
        bit_cnt_next       = bit_cnt_reg;
        slot_next          = slot_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_winner_id_next   = m_winner_id_reg;
        m_winner_slot_next = m_winner_slot_reg;
        unique case (state_reg)
            lsch_pkg::S_IDLE: begin
                slot_next = '0;
                if (s_accept) begin
                    rem_next           = '0;
                    rnd_next           = s_random_value;
                    bit_cnt_next       = '0;
                    m_winner_id_next   = '0;
                    m_winner_slot_next = '0;
                    if (s_command == lsch_pkg::CMD_ADD) begin
                        m_valid_next = 1'b1;
                        if (table_full) begin
                            m_status_next = lsch_pkg::ST_FULL;
                        end else begin
                            m_status_next = lsch_pkg::ST_ADDED;
                            count_next    = count_reg + CNT_W'(1);
                            total_next    = total_reg + TOTAL_W'(tickets_in);
                        end
                    end else if (!draw_go) begin
                        m_valid_next  = 1'b1;
                        m_status_next = lsch_pkg::ST_EMPTY;
                    end
                end
            end
            lsch_pkg::S_DIV: begin
                slot_next    = '0;
                rnd_next     = {rnd_reg[lsch_pkg::RND_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + lsch_pkg::DIV_CNT_W'(1);
                if (unit_borrow) begin
                    rem_next = unit_a[TOTAL_W-1:0];
                end else begin
                    rem_next = unit_diff[TOTAL_W-1:0];
                end
            end
            lsch_pkg::S_WALK: begin
                if (unit_borrow) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = lsch_pkg::ST_WINNER;
                    m_winner_id_next   = rd_id;
                    m_winner_slot_next = lsch_pkg::SLOT_OUT_W'(slot_reg);
                end else if (walk_last) begin
                    m_valid_next  = 1'b1;
                    m_status_next = lsch_pkg::ST_EMPTY;
                end else begin
                    rem_next  = unit_diff[TOTAL_W-1:0];
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            default: begin
                slot_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsch_pkg::S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            slot_reg    <= '0;
            bit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            slot_reg    <= slot_next;
            bit_cnt_reg <= bit_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg           <= rem_next;
        rnd_reg           <= rnd_next;
        m_status_reg      <= m_status_next;
        m_winner_id_reg   <= m_winner_id_next;
        m_winner_slot_reg <= m_winner_slot_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_winner_id   = m_winner_id_reg;
    assign m_winner_slot = m_winner_slot_reg;

endmodule

### verif/tb_lottery_scheduler.sv
// ----------------------------------------------------------------------------
// Lottery scheduler testbench
// Drives add and draw commands into the scheduler and checks every result
// against a predictor that keeps its own ticket table. Directed tests cover
// the empty table, a zero ticket total, ticket extremes and a full table. A
// long random mix fills the table and draws winners from it. Random
// idle gaps on both channels, a long receiver hold-off and a drain pause
// exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_lottery_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_ENTRIES   = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic [lsch_pkg::STATUS_W-1:0]   status;
        logic [lsch_pkg::ID_W-1:0]       id;
        logic [lsch_pkg::SLOT_OUT_W-1:0] slot;
    } outcome_t;

    logic                             aclk           = 1'b0;
    logic                             aresetn        = 1'b0;
    logic                             s_valid        = 1'b0;
    logic                             s_ready;
    logic                             s_command      = lsch_pkg::CMD_ADD;
    logic [lsch_pkg::ID_W-1:0]        s_process_id   = '0;
    logic [lsch_pkg::TICKET_IN_W-1:0] s_ticket_count = '0;
    logic [lsch_pkg::RND_W-1:0]       s_random_value = '0;
    logic                             m_valid;
    logic                             m_ready        = 1'b0;
    logic [lsch_pkg::STATUS_W-1:0]    m_status;
    logic [lsch_pkg::ID_W-1:0]        m_winner_id;
    logic [lsch_pkg::SLOT_OUT_W-1:0]  m_winner_slot;

    logic [lsch_pkg::ID_W-1:0]        slot_ids     [TB_ENTRIES];
    logic [lsch_pkg::TICKET_IN_W-1:0] slot_tickets [TB_ENTRIES];
    int                               entry_count = 0;
    longint unsigned                  ticket_sum  = 0;

    outcome_t pending_outcomes [$];
    int       mismatch_count = 0;
    int       idle_cycles    = 0;
    bit       tx_gaps        = 1'b0;
    bit       rx_gaps        = 1'b0;
    bit       hold_rx        = 1'b0;

    lottery_scheduler #(
        .MAX_ENTRIES (TB_ENTRIES),
        .TICKET_BITS (lsch_pkg::TICKET_IN_W)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_process_id   (s_process_id),
        .s_ticket_count (s_ticket_count),
        .s_random_value (s_random_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_winner_id    (m_winner_id),
        .m_winner_slot  (m_winner_slot)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic outcome_t lottery_outcome(logic cmd, logic [lsch_pkg::ID_W-1:0] pid,
                                                 logic [lsch_pkg::TICKET_IN_W-1:0] tickets,
                                                 logic [lsch_pkg::RND_W-1:0] rnd);
        outcome_t        o;
        longint unsigned winning;
        longint unsigned running;
        o = '0;
        if (cmd == lsch_pkg::CMD_ADD) begin
            if (entry_count >= TB_ENTRIES) begin
                o.status = lsch_pkg::ST_FULL;
            end else begin
                slot_ids[entry_count]     = pid;
                slot_tickets[entry_count] = tickets;
                entry_count++;
                ticket_sum += 64'(tickets);
                o.status = lsch_pkg::ST_ADDED;
            end
        end else begin
            o.status = lsch_pkg::ST_EMPTY;
            if (entry_count != 0 && ticket_sum != 0) begin
                winning = (longint'(rnd) % ticket_sum) + 1;
                running = 0;
                for (int i = 0; i < entry_count; i++) begin
                    running += 64'(slot_tickets[i]);
                    if (running >= winning) begin
                        o.status = lsch_pkg::ST_WINNER;
                        o.id     = slot_ids[i];
                        o.slot   = lsch_pkg::SLOT_OUT_W'(i);
                        break;
                    end
                end
            end
        end
        return o;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    endfunction

    function automatic logic [lsch_pkg::TICKET_IN_W-1:0] pick_tickets();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return lsch_pkg::TICKET_IN_W'($urandom_range(1, 15));
            default: return lsch_pkg::TICKET_IN_W'($urandom);
        endcase
    endfunction

    function automatic logic [lsch_pkg::RND_W-1:0] pick_draw_value();
        longint unsigned span;
        longint unsigned k;
        if (ticket_sum == 0) return lsch_pkg::RND_W'($urandom);
        span = 64'hFFFF_FFFF / ticket_sum;
        k    = longint'($urandom) % span;
        case ($urandom_range(0, 7))
            0:       return lsch_pkg::RND_W'(k * ticket_sum + ticket_sum - 1);
            1:       return lsch_pkg::RND_W'(k * ticket_sum);
            2:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return lsch_pkg::RND_W'($urandom);
        endcase
    endfunction

    // Starts and ends on a rising edge; valid stays high after the transfer.
    task automatic send_item(logic cmd, logic [lsch_pkg::ID_W-1:0] pid,
                             logic [lsch_pkg::TICKET_IN_W-1:0] tickets,
                             logic [lsch_pkg::RND_W-1:0] rnd);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_process_id   <= pid;
        s_ticket_count <= tickets;
        s_random_value <= rnd;
        do @(negedge aclk); while (!s_ready);
        pending_outcomes = {pending_outcomes, lottery_outcome(cmd, pid, tickets, rnd)};
        @(posedge aclk);
    endtask

    task automatic add_entry(logic [lsch_pkg::ID_W-1:0] pid,
                             logic [lsch_pkg::TICKET_IN_W-1:0] tickets);
        send_item(lsch_pkg::CMD_ADD, pid, tickets, lsch_pkg::RND_W'($urandom));
    endtask

    task automatic draw(logic [lsch_pkg::RND_W-1:0] rnd);
        send_item(lsch_pkg::CMD_DRAW, lsch_pkg::ID_W'($urandom),
                  lsch_pkg::TICKET_IN_W'($urandom), rnd);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_table();
        draw('0);
        draw('1);
    endtask

    task automatic test_zero_total();
        add_entry('0, '0);
        draw('0);
        add_entry('1, '0);
        draw('1);
    endtask

    // Total becomes 65536 with two leading zero-ticket entries that must never win.
    task automatic test_ticket_extremes();
        add_entry(8'hFF, 16'hFFFF);
        add_entry(8'hA5, 16'h0001);
        draw('0);
        draw(32'd65534);
        draw(32'd65535);
        draw('1);
        draw(32'd65536);
    endtask

    task automatic test_backpressure();
        tx_gaps = 1'b0;
        hold_rx = 1'b1;
        repeat (5) begin
            if ($urandom_range(0, 1) == 0) add_entry(lsch_pkg::ID_W'($urandom), pick_tickets());
            else draw(pick_draw_value());
        end
    endtask

    task automatic test_drain_pause();
        drain_results();
        add_entry(lsch_pkg::ID_W'($urandom), pick_tickets());
        draw(pick_draw_value());
        drain_results();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 3) == 0) add_entry(lsch_pkg::ID_W'($urandom), pick_tickets());
            else draw(pick_draw_value());
        end
    endtask

    task automatic test_table_full();
        while (entry_count < TB_ENTRIES) add_entry(lsch_pkg::ID_W'($urandom), pick_tickets());
        add_entry('1, '1);
        add_entry('0, '0);
        draw('0);
        draw('1);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: status mismatch, expected no result, actual %0d",
                         $time, m_status);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("winner_id", 32'(want.id), 32'(m_winner_id));
                check_field("winner_slot", 32'(want.slot), 32'(m_winner_slot));
            end
        end
    end

    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_lottery_scheduler NOT OK");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_zero_total();
        test_ticket_extremes();
        test_backpressure();
        test_drain_pause();
        test_random_mix();
        test_table_full();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("tb_lottery_scheduler OK");
        end else begin
            $display("tb_lottery_scheduler NOT OK");
        end
        $finish;
    end

endmodule
